[hw/rtl/ubpf_pkg.sv]
// Shared types and constants for the owner-id blocklist packet filter.
// No dependencies; every other RTL file of the block imports this package.
package ubpf_pkg;

  localparam int BUCKET_BITS_DEF = 8;
  localparam int WAYS_DEF        = 4;

  localparam int ID_W        = 32;
  localparam int REQ_W       = 2;
  localparam int STATUS_W    = 3;
  localparam int OCC_W       = 11;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam logic [ID_W-1:0] HASH_MUL     = 32'h61C8_8647;
  localparam logic [ID_W-1:0] MIN_ID_RESET = 32'd10000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLOCKED   = 1'b1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CHECK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_ACCEPT   = 3'd0;
  localparam logic [STATUS_W-1:0] STS_DROP     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_ADDED    = 3'd2;
  localparam logic [STATUS_W-1:0] STS_PRESENT  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;
  localparam logic [STATUS_W-1:0] STS_REMOVED  = 3'd5;
  localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd6;
  localparam logic [STATUS_W-1:0] STS_CLEARED  = 3'd7;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE
  } ctrl_state_t;

  typedef struct packed {
    logic accept;   // capture request fields and bucket
    logic lookup;   // read the bucket row
    logic decide;   // resolve, write back, load result
    logic sweep;    // zero one valid row
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic res_busy;
    logic req_clear;
  } dp_status_t;

endpackage

[hw/rtl/ubpf_req_if.sv]
// Request channel: valid/ready handshake carrying one filter request.
// Depends on ubpf_pkg for field widths.
interface ubpf_req_if
  import ubpf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [ID_W-1:0]  owner_id;
  logic             owner_valid;
  logic             egress_local;

  modport source (output valid, req_type, owner_id, owner_valid, egress_local, input ready);
  modport sink   (input valid, req_type, owner_id, owner_valid, egress_local, output ready);
endinterface

[hw/rtl/ubpf_res_if.sv]
// Result channel: valid/ready handshake carrying one filter result.
// Depends on ubpf_pkg for field widths.
interface ubpf_res_if
  import ubpf_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                drop;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, drop, status, occupancy, input ready);
  modport sink   (input valid, drop, status, occupancy, output ready);
endinterface

[hw/rtl/ubpf_ctrl.sv]
// Sequencer for the filter: reset sweep, lookup, decide and clear sweep.
// Depends on ubpf_pkg for the state, command and status types.
module ubpf_ctrl
  import ubpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        sweep_for_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_SWEEP;
      sweep_for_clear <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_LOOKUP && status.req_clear) begin
        sweep_for_clear <= 1'b1;
      end else if (state == ST_DECIDE) begin
        sweep_for_clear <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_SWEEP: begin
        if (status.sweep_last) begin
          state_next = sweep_for_clear ? ST_DECIDE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_next = status.req_clear ? ST_SWEEP : ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!status.res_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_SWEEP;
    endcase
  end

  always_comb begin
    req_ready  = (state == ST_IDLE);
    cmd.accept = (state == ST_IDLE) && req_valid;
    cmd.lookup = (state == ST_LOOKUP);
    cmd.decide = (state == ST_DECIDE) && !status.res_busy;
    cmd.sweep  = (state == ST_SWEEP);
  end

endmodule

[hw/rtl/ubpf_datapath.sv]
// Datapath: hash, bucket memories, way compare, occupancy count, config
// registers and result register. Depends on ubpf_pkg.
module ubpf_datapath
  import ubpf_pkg::*;
#(
  parameter int BUCKET_BITS     = BUCKET_BITS_DEF,
  parameter int WAYS_PER_BUCKET = WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [ID_W-1:0]       owner_id,
  input  logic                  owner_valid,
  input  logic                  egress_local,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic                  res_drop,
  output logic [STATUS_W-1:0]   res_status,
  output logic [OCC_W-1:0]      res_occupancy,
  input  dp_cmd_t               cmd,
  output dp_status_t            status
);

  localparam int NBUCKETS = 1 << BUCKET_BITS;
  localparam int WAYS     = WAYS_PER_BUCKET;

  typedef logic [WAYS-1:0]           way_vec_t;
  typedef logic [WAYS-1:0][ID_W-1:0] id_row_t;

  // bucket row memories
  way_vec_t valid_mem [NBUCKETS];
  id_row_t  id_mem    [NBUCKETS];

  logic                   filter_enable;
  logic [ID_W-1:0]        min_blocked_id;
  logic [REQ_W-1:0]       req_q;
  logic [ID_W-1:0]        id_q;
  logic                   ovalid_q;
  logic                   lout_q;
  logic [BUCKET_BITS-1:0] bucket;
  logic [BUCKET_BITS-1:0] sweep_cnt;
  way_vec_t               rd_valid;
  id_row_t                rd_ids;
  logic [OCC_W-1:0]       count;

  logic [ID_W-1:0]        hash;
  way_vec_t               hit;
  way_vec_t               free_oh;
  logic                   hit_any;
  logic                   free_any;
  way_vec_t               valid_row_next;
  id_row_t                id_row_next;
  logic                   valid_we;
  logic                   id_we;
  logic [OCC_W-1:0]       count_next;
  logic [STATUS_W-1:0]    status_next;
  logic                   drop_next;

  assign hash = owner_id * HASH_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable  <= 1'b0;
      min_blocked_id <= MIN_ID_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_ENABLE: filter_enable  <= cfg_data[0];
        CFG_MIN_BLOCKED:   min_blocked_id <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // capture request and its bucket
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_q    <= req_type;
      id_q     <= owner_id;
      ovalid_q <= owner_valid;
      lout_q   <= egress_local;
      bucket   <= hash[ID_W-1 -: BUCKET_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rd_valid <= valid_mem[bucket];
      rd_ids   <= id_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      valid_mem[sweep_cnt] <= '0;
    end else if (valid_we) begin
      valid_mem[bucket] <= valid_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (id_we) begin
      id_mem[bucket] <= id_row_next;
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hit[w] = rd_valid[w] && (rd_ids[w] == id_q);
    end
    hit_any  = |hit;
    // lowest clear bit of the valid row
    free_oh  = ~rd_valid & (rd_valid + way_vec_t'(1));
    free_any = |free_oh;
    for (int w = 0; w < WAYS; w++) begin
      id_row_next[w] = free_oh[w] ? id_q : rd_ids[w];
    end

    valid_row_next = rd_valid;
    valid_we       = 1'b0;
    id_we          = 1'b0;
    count_next     = count;
    drop_next      = 1'b0;
    status_next    = STS_ACCEPT;
    case (req_q)
      REQ_CHECK: begin
        if (filter_enable && lout_q && ovalid_q && (id_q >= min_blocked_id) && hit_any) begin
          drop_next   = 1'b1;
          status_next = STS_DROP;
        end
      end
      REQ_ADD: begin
        if (hit_any) begin
          status_next = STS_PRESENT;
        end else if (free_any) begin
          valid_row_next = rd_valid | free_oh;
          valid_we       = cmd.decide;
          id_we          = cmd.decide;
          count_next     = count + 1'b1;
          status_next    = STS_ADDED;
        end else begin
          status_next = STS_FULL;
        end
      end
      REQ_REMOVE: begin
        if (hit_any) begin
          valid_row_next = rd_valid & ~hit;
          valid_we       = cmd.decide;
          count_next     = count - 1'b1;
          status_next    = STS_REMOVED;
        end else begin
          status_next = STS_NOTFOUND;
        end
      end
      REQ_CLEAR: begin
        count_next  = '0;
        status_next = STS_CLEARED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.decide) begin
      count <= count_next;
    end
  end

  // result register; holds until transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.decide) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      res_drop      <= drop_next;
      res_status    <= status_next;
      res_occupancy <= count_next;
    end
  end

  assign status.sweep_last = (sweep_cnt == BUCKET_BITS'(NBUCKETS - 1));
  assign status.res_busy   = res_valid && !res_ready;
  assign status.req_clear  = (req_q == REQ_CLEAR);

endmodule

[hw/rtl/uid_blocklist_packet_filter.sv]
// Top level of the owner-id blocklist packet filter.
// Depends on ubpf_pkg, ubpf_req_if, ubpf_res_if, ubpf_ctrl, ubpf_datapath.
//
// Usage:
//   req  - request channel (check, add, remove, clear); one transfer per item.
//   res  - result channel; exactly one result per request, in order.
//   cfg_we/cfg_index/cfg_data - register writes (0 filter enable, 1 minimum
//          blocked id), taken at any edge with cfg_we high; write only while idle.
// Timing:
//   A check, add or remove steps the sequencer through idle, lookup and decide:
//   idle takes the transfer and registers the bucket hash, lookup reads the
//   bucket row, decide compares all ways, writes the row back and loads the
//   result register. A new item is taken only after the last one leaves
//   decide, and decide waits while the result register is still full.
//   A clear zeroes the valid rows one bucket per cycle between lookup and
//   decide.
// Reset and stall:
//   After rst the same sweep zeroes every valid row with req.ready low;
//   config writes are taken during it. A stalled result holds its register;
//   the next item waits in decide until the register frees.
module uid_blocklist_packet_filter
  import ubpf_pkg::*;
#(
  parameter int BUCKET_BITS     = BUCKET_BITS_DEF,
  parameter int WAYS_PER_BUCKET = WAYS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ubpf_req_if.sink              req,
  ubpf_res_if.source            res
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       req_ready;

  // Sequencer: owns the handshake on req and steps the datapath.
  ubpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  assign req.ready = req_ready;

  // Datapath: hash, bucket memories, compare, count, result register.
  ubpf_datapath #(
    .BUCKET_BITS     (BUCKET_BITS),
    .WAYS_PER_BUCKET (WAYS_PER_BUCKET)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req.req_type),
    .owner_id      (req.owner_id),
    .owner_valid   (req.owner_valid),
    .egress_local  (req.egress_local),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_drop      (res.drop),
    .res_status    (res.status),
    .res_occupancy (res.occupancy),
    .cmd           (cmd),
    .status        (status)
  );

endmodule

[tb/tb_top.sv]
// Self-checking bench for the owner-id blocklist packet filter.
// Needs ubpf_pkg, ubpf_req_if, ubpf_res_if and the uid_blocklist_packet_filter RTL.
`timescale 1ns / 100ps
module tb_top;
  import ubpf_pkg::*;

  localparam int  DEPTH        = (1 << BUCKET_BITS_DEF) * WAYS_DEF;
  localparam int  CYCLE_LIMIT  = 400_000;
  localparam int  DRAIN_CYCLES = 8;    // quiet cycles after the last result
  localparam int  HOLD_AT      = 60;   // results seen before the long receiver hold-off
  localparam int  HOLD_CYCLES  = 300;
  localparam int  PHASES       = 6;
  localparam int  PHASE_ITEMS  = 250;
  localparam int  POOL_SIZE    = 32;
  localparam int  HOT_IDS      = 10;   // pool ids that all share one bucket
  localparam int  SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [ID_W-1:0]  owner_id;
    logic             owner_valid;
    logic             egress_local;
  } filter_req_t;

  typedef struct packed {
    logic                drop;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } filter_verdict_t;

  // One line of the directed script: either a register write or a request,
  // the latter optionally with its result typed in.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_value;
    filter_req_t           request;
    bit                    typed;
    filter_verdict_t       verdict;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ubpf_req_if req_ch ();
  ubpf_res_if res_ch ();

  uid_blocklist_packet_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .res       (res_ch)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Blocklist shadow: the bench's own copy of the set and the two registers.
  // ---------------------------------------------------------------------------
  bit              set_valid [DEPTH];
  logic [ID_W-1:0] set_id    [DEPTH];
  int              set_count;
  bit              shadow_enable;
  logic [ID_W-1:0] shadow_min_id;

  filter_verdict_t pending_verdicts[$];

  int tx_idle_pct;
  int rx_stall_pct;
  int requests_sent;
  int results_seen = 0;
  int fail_count = 0;
  int status_seen [8] = '{default: 0};
  int cycle_count = 0;
  int hold_left = 0;
  bit hold_done = 0;

  logic [ID_W-1:0] id_pool   [POOL_SIZE];
  logic [ID_W-1:0] phase_min [PHASES];
  bit              phase_en  [PHASES] = '{1, 0, 1, 1, 1, 1};
  // idle mixes: none, sender idle, receiver stall, both
  int              phase_tx  [PHASES] = '{0, 80, 0, 38, 0, 38};
  int              phase_rx  [PHASES] = '{0, 0, 80, 38, 0, 38};

  script_row_t directed_rows[$];

  // Bucket index: top bits of the 32-bit golden-ratio product.
  function automatic int bucket_of_id(logic [ID_W-1:0] id);
    logic [ID_W-1:0] h;
    h = id * HASH_MUL;
    return int'(h >> (ID_W - BUCKET_BITS_DEF));
  endfunction

  // Slot that holds id, or -1 when id is not in the set.
  function automatic int locate_id(logic [ID_W-1:0] id);
    int base;
    int slot;
    base = bucket_of_id(id) * WAYS_DEF;
    slot = -1;
    for (int w = 0; w < WAYS_DEF; w++) begin
      if (slot < 0 && set_valid[base + w] && set_id[base + w] == id) slot = base + w;
    end
    return slot;
  endfunction

  // Walk ids up or down from a start point until one lands in the given bucket.
  function automatic logic [ID_W-1:0] next_in_bucket(logic [ID_W-1:0] from, int bucket,
                                                     bit downward);
    logic [ID_W-1:0] id;
    id = downward ? from - 1 : from + 1;
    while (bucket_of_id(id) != bucket) id = downward ? id - 1 : id + 1;
    return id;
  endfunction

  // Apply one request to the shadow set and return the result it must produce.
  function automatic filter_verdict_t predict_verdict(filter_req_t rq);
    filter_verdict_t v;
    int              slot;
    int              base;
    bit              placed;
    v      = '0;
    slot   = locate_id(rq.owner_id);
    base   = bucket_of_id(rq.owner_id) * WAYS_DEF;
    placed = 1'b0;
    case (rq.req_type)
      REQ_CHECK: begin
        v.status = STS_ACCEPT;
        if (shadow_enable && rq.egress_local && rq.owner_valid &&
            rq.owner_id >= shadow_min_id && slot >= 0) begin
          v.drop   = 1'b1;
          v.status = STS_DROP;
        end
      end
      REQ_ADD: begin
        if (slot >= 0) begin
          v.status = STS_PRESENT;
        end else begin
          // take the lowest free way; no free way means the bucket is full
          v.status = STS_FULL;
          for (int w = 0; w < WAYS_DEF; w++) begin
            if (!placed && !set_valid[base + w]) begin
              set_valid[base + w] = 1'b1;
              set_id[base + w]    = rq.owner_id;
              set_count++;
              placed   = 1'b1;
              v.status = STS_ADDED;
            end
          end
        end
      end
      REQ_REMOVE: begin
        if (slot >= 0) begin
          set_valid[slot] = 1'b0;
          set_count--;
          v.status = STS_REMOVED;
        end else begin
          v.status = STS_NOTFOUND;
        end
      end
      default: begin
        foreach (set_valid[i]) set_valid[i] = 1'b0;
        set_count = 0;
        v.status  = STS_CLEARED;
      end
    endcase
    v.occupancy = set_count[OCC_W-1:0];
    return v;
  endfunction

  function automatic void add_row(bit typed, logic [REQ_W-1:0] rt, logic [ID_W-1:0] id,
                                  bit ov, bit lo, bit d = 1'b0,
                                  logic [STATUS_W-1:0] st = STS_ACCEPT,
                                  logic [OCC_W-1:0] occ = '0);
    script_row_t row;
    row         = '{default: '0};
    row.request = '{req_type: rt, owner_id: id, owner_valid: ov, egress_local: lo};
    row.typed   = typed;
    row.verdict = '{drop: d, status: st, occupancy: occ};
    directed_rows.push_back(row);
  endfunction

  function automatic void add_cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    script_row_t row;
    row           = '{default: '0};
    row.is_cfg    = 1'b1;
    row.cfg_index = idx;
    row.cfg_value = val;
    directed_rows.push_back(row);
  endfunction

  // Mostly ids from the pool so adds, removes and checks keep meeting each
  // other; one in ten is a fully random id.
  function automatic filter_req_t random_request();
    filter_req_t rq;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 45)      rq.req_type = REQ_CHECK;
    else if (pick < 75) rq.req_type = REQ_ADD;
    else if (pick < 97) rq.req_type = REQ_REMOVE;
    else                rq.req_type = REQ_CLEAR;
    rq.owner_id     = ($urandom_range(0, 9) == 0) ? $urandom
                                                  : id_pool[$urandom_range(0, POOL_SIZE-1)];
    rq.owner_valid  = ($urandom_range(0, 7) != 0);
    rq.egress_local = ($urandom_range(0, 7) != 0);
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Every task starts and ends right after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one request, idling first at the current rate; hold it until the
  // transfer, then record the result it must produce.
  task automatic offer(filter_req_t rq, bit typed = 1'b0,
                       filter_verdict_t typed_verdict = '0);
    filter_verdict_t v;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= rq.req_type;
    req_ch.owner_id     <= rq.owner_id;
    req_ch.owner_valid  <= rq.owner_valid;
    req_ch.egress_local <= rq.egress_local;
    do @(posedge clk); while (!req_ch.ready);
    // transfer at this edge; valid stays up unless the caller drops it
    v = predict_verdict(rq);
    if (typed) v = typed_verdict;
    pending_verdicts.push_back(v);
    requests_sent++;
  endtask

  // Drop valid and let every outstanding result come back before a register write.
  task automatic quiesce();
    req_ch.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; ends only after an edge with the strobe low, so writes can chain.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FILTER_ENABLE) shadow_enable = val[0];
    else                          shadow_min_id = val;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern, with one long hold-off to back the block up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      res_ch.ready <= 1'b0;
      hold_left    <= HOLD_CYCLES;
      hold_done    <= 1'b1;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    filter_verdict_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_seen++;
      status_seen[res_ch.status]++;
      if (pending_verdicts.size() == 0) begin
        if (fail_count < SHOW_LIMIT)
          $display("%0t: result with nothing expected: drop %0b status %0d occupancy %0d",
                   $realtime, res_ch.drop, res_ch.status, res_ch.occupancy);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (res_ch.drop !== want.drop || res_ch.status !== want.status ||
            res_ch.occupancy !== want.occupancy) begin
          if (fail_count < SHOW_LIMIT)
            $display({"%0t: result %0d mismatch: drop %0b/%0b status %0d/%0d ",
                      "occupancy %0d/%0d (exp/got)"},
                     $realtime, results_seen, want.drop, res_ch.drop, want.status,
                     res_ch.status, want.occupancy, res_ch.occupancy);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_verdicts.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    logic [ID_W-1:0] mate [5];
    logic [ID_W-1:0] hot;
    int              hot_bucket;

    requests_sent      = 0;
    tx_idle_pct        = 0;
    rx_stall_pct       = 0;
    // shadow starts at reset values
    foreach (set_valid[i]) set_valid[i] = 1'b0;
    set_count     = 0;
    shadow_enable = 1'b0;
    shadow_min_id = MIN_ID_RESET;

    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_FILTER_ENABLE;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= REQ_CHECK;
    req_ch.owner_id     <= '0;
    req_ch.owner_valid  <= 1'b0;
    req_ch.egress_local <= 1'b0;

    // Five ids sharing the bucket of the all-ones id, all far above the minimum.
    mate[0] = '1;
    for (int i = 1; i < 5; i++)
      mate[i] = next_in_bucket(mate[i-1], bucket_of_id(mate[0]), 1'b1);

    // Directed script: reset values, the drop gates one by one, duplicate add,
    // full bucket, way reuse after remove, minimum id at both extremes, clear.
    add_row(1, REQ_CHECK,  '0,      0, 0, 0, STS_ACCEPT,   0);
    add_row(1, REQ_REMOVE, mate[0], 1, 1, 0, STS_NOTFOUND, 0);
    add_row(1, REQ_CLEAR,  mate[0], 1, 1, 0, STS_CLEARED,  0);
    add_row(1, REQ_ADD,    mate[0], 0, 0, 0, STS_ADDED,    1);
    add_row(1, REQ_ADD,    mate[0], 1, 1, 0, STS_PRESENT,  1);
    add_row(1, REQ_CHECK,  mate[0], 1, 1, 0, STS_ACCEPT,   1);  // filtering still off
    add_cfg_row(CFG_FILTER_ENABLE, 32'd1);
    add_row(1, REQ_CHECK,  mate[0], 1, 1, 1, STS_DROP,     1);
    add_row(1, REQ_CHECK,  mate[0], 0, 1, 0, STS_ACCEPT,   1);  // no owner
    add_row(1, REQ_CHECK,  mate[0], 1, 0, 0, STS_ACCEPT,   1);  // not local output
    add_row(0, REQ_CHECK,  mate[1], 1, 1);                      // id not in the set
    add_row(0, REQ_ADD,    mate[1], 0, 1);
    add_row(0, REQ_ADD,    mate[2], 1, 0);
    add_row(0, REQ_ADD,    mate[3], 0, 0);
    add_row(0, REQ_ADD,    mate[4], 1, 1);                      // bucket full
    add_row(0, REQ_REMOVE, mate[1], 1, 1);
    add_row(0, REQ_ADD,    mate[4], 0, 0);                      // lands in the freed way
    add_row(0, REQ_CHECK,  mate[4], 1, 1);
    add_cfg_row(CFG_MIN_BLOCKED, '1);
    add_row(0, REQ_CHECK,  mate[4], 1, 1);                      // below the minimum
    add_row(1, REQ_CHECK,  mate[0], 1, 1, 1, STS_DROP,     4);  // equal to the minimum
    add_cfg_row(CFG_MIN_BLOCKED, '0);
    add_row(0, REQ_ADD,    '0,      1, 1);
    add_row(0, REQ_CHECK,  '0,      1, 1);
    add_row(0, REQ_REMOVE, '0,      0, 0);
    add_row(1, REQ_CLEAR,  32'h5A5A_A5A5, 1, 1, 0, STS_CLEARED, 0);
    add_row(1, REQ_CHECK,  mate[0], 1, 1, 0, STS_ACCEPT,   0);

    // Random pool: a crowded bucket, ids near the reset minimum, and wide ids.
    hot        = $urandom;
    hot_bucket = bucket_of_id(hot);
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < HOT_IDS) begin
        id_pool[i] = hot;
        hot        = next_in_bucket(hot, hot_bucket, 1'b0);
      end else if (i < (POOL_SIZE + HOT_IDS) / 2) begin
        id_pool[i] = $urandom_range(0, 20000);
      end else begin
        id_pool[i] = $urandom;
      end
    end
    phase_min = '{32'd10000, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd0};
    phase_min[PHASES-1] = $urandom_range(0, 20000);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed script with no idling; the reset sweep simply shows
    // up as a long wait on the first transfer.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        quiesce();
        write_reg(directed_rows[i].cfg_index, directed_rows[i].cfg_value);
      end else begin
        offer(directed_rows[i].request, directed_rows[i].typed, directed_rows[i].verdict);
      end
    end

    // Random phases, each with its own register setting and idle mix.
    for (int p = 0; p < PHASES; p++) begin
      quiesce();
      write_reg(CFG_FILTER_ENABLE, {31'd0, phase_en[p]});
      write_reg(CFG_MIN_BLOCKED, phase_min[p]);
      tx_idle_pct  = phase_tx[p];
      rx_stall_pct = phase_rx[p];
      for (int n = 0; n < PHASE_ITEMS; n++) offer(random_request());
    end

    // Let every outstanding result drain, then DRAIN_CYCLES of quiet.
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    quiesce();

    $display("Run covered %0d requests and %0d results: %0d drops, %0d accepts,",
             requests_sent, results_seen, status_seen[STS_DROP], status_seen[STS_ACCEPT]);
    $display({"%0d full buckets, %0d clears; filter on and off, minimum id 0 to all ones, ",
              "idle/stall mixes and a %0d-cycle output hold; %0d mismatches."},
             status_seen[STS_FULL], status_seen[STS_CLEARED], HOLD_CYCLES, fail_count);
    if (fail_count == 0 && pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[uid_blocklist_packet_filter.f]
hw/rtl/ubpf_pkg.sv
hw/rtl/ubpf_req_if.sv
hw/rtl/ubpf_res_if.sv
hw/rtl/ubpf_ctrl.sv
hw/rtl/ubpf_datapath.sv
hw/rtl/uid_blocklist_packet_filter.sv
tb/tb_top.sv
